// ----- hw/rtl/bsfe_pkg.sv -----
// Shared types, constants and helper functions for the byte-stuffing frame encoder.
package bsfe_pkg;

    // Framing, escape and header byte values.
    localparam logic [7:0] FLAG_BYTE = 8'h5C;
    localparam logic [7:0] ESC_BYTE  = 8'h5D;
    localparam logic [7:0] ESC_FLAG  = 8'h7C;
    localparam logic [7:0] ESC_ESC   = 8'h7D;
    localparam logic [7:0] HDR_ADDR  = 8'h03;
    localparam logic [7:0] HDR_CTRL  = 8'h07;
    localparam logic [7:0] HDR_BCC   = 8'h04;

    // Command queue geometry.
    localparam int QDepth = 2;
    localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCntW  = $clog2(QDepth + 1);

    // One input transfer.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } bsfe_in_t;

    // One output transfer.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       frame_end;
    } bsfe_out_t;

    // Classified work item passed from the front end to the serializer.
    typedef struct packed {
        logic       hdr;
        logic [7:0] data;
        logic       last;
        logic [7:0] chk;
    } bsfe_cmd_t;

    // Queue status seen by the front end and the serializer.
    typedef struct packed {
        logic full;
        logic empty;
    } bsfe_qstat_t;

    // Serializer phases.
    typedef enum logic [3:0] {
        PH_START,
        PH_HDR0,
        PH_HDR1,
        PH_HDR2,
        PH_HDR3,
        PH_DATA,
        PH_DATA2,
        PH_CHK,
        PH_CHK2,
        PH_FLAG
    } bsfe_phase_t;

    // True when a byte must be sent as an escape pair.
    function automatic logic needs_esc(input logic [7:0] b);
        needs_esc = (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

    // Second byte of the escape pair.
    function automatic logic [7:0] esc_code(input logic [7:0] b);
        esc_code = (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
    endfunction

endpackage

// ----- hw/rtl/bsfe_front.sv -----
// Front end: accepts payload bytes, tracks frame state and the running XOR check.
module bsfe_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bsfe_pkg::bsfe_in_t   in_data,
    input  bsfe_pkg::bsfe_qstat_t q_stat,
    output logic                 push,
    output bsfe_pkg::bsfe_cmd_t  push_cmd
);

    logic       in_frame_reg;
    logic       in_frame_next;
    logic [7:0] check_accum_reg;
    logic [7:0] check_accum_next;
    logic       hdr;
    logic [7:0] acc_new;

    // Classify the incoming byte and build the command for the serializer.
    always_comb
    begin
        hdr              = !in_frame_reg;
        acc_new          = (hdr ? 8'h00 : check_accum_reg) ^ in_data.data_byte;
        in_ready         = !q_stat.full;
        push             = in_valid && in_ready;
        push_cmd.hdr     = hdr;
        push_cmd.data    = in_data.data_byte;
        push_cmd.last    = in_data.last_byte;
        push_cmd.chk     = acc_new;
        in_frame_next    = in_frame_reg;
        check_accum_next = check_accum_reg;
        if (push)
        begin
            in_frame_next    = !in_data.last_byte;
            check_accum_next = in_data.last_byte ? 8'h00 : acc_new;
        end
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            check_accum_reg <= 8'h00;
        end
        else
        begin
            in_frame_reg    <= in_frame_next;
            check_accum_reg <= check_accum_next;
        end
    end

    // A closed frame always leaves the check cleared.
    a_closed_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> check_accum_reg == 8'h00)
        else $error("check not cleared outside a frame");

    // A transfer flagged last closes the frame.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (push && in_data.last_byte) |=> !in_frame_reg)
        else $error("frame left open after last byte");

    // A transfer not flagged last leaves the frame open.
    a_open_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !in_data.last_byte) |=> in_frame_reg)
        else $error("frame closed without last byte");

endmodule

// ----- hw/rtl/bsfe_queue.sv -----
// Short command queue between the front end and the serializer.
module bsfe_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bsfe_pkg::bsfe_cmd_t   push_cmd,
    input  logic                  pop,
    output bsfe_pkg::bsfe_cmd_t   head,
    output bsfe_pkg::bsfe_qstat_t q_stat
);

    bsfe_pkg::bsfe_cmd_t             entry_reg [bsfe_pkg::QDepth];
    logic [bsfe_pkg::QPtrW-1:0]      wptr_reg;
    logic [bsfe_pkg::QPtrW-1:0]      wptr_next;
    logic [bsfe_pkg::QPtrW-1:0]      rptr_reg;
    logic [bsfe_pkg::QPtrW-1:0]      rptr_next;
    logic [bsfe_pkg::QCntW-1:0]      count_reg;
    logic [bsfe_pkg::QCntW-1:0]      count_next;

    localparam logic [bsfe_pkg::QPtrW-1:0] LastPtr = bsfe_pkg::QPtrW'(bsfe_pkg::QDepth - 1);
    localparam logic [bsfe_pkg::QCntW-1:0] FullCnt = bsfe_pkg::QCntW'(bsfe_pkg::QDepth);

    // Pointer and occupancy updates.
    always_comb
    begin
        q_stat.full  = (count_reg == FullCnt);
        q_stat.empty = (count_reg == '0);
        head         = entry_reg[rptr_reg];
        wptr_next    = wptr_reg;
        rptr_next    = rptr_reg;
        count_next   = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == LastPtr) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == LastPtr) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

    // Occupancy never exceeds the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FullCnt)
        else $error("queue overfilled");

    // No removal from an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // No insertion into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

endmodule

// ----- hw/rtl/bsfe_back.sv -----
// Serializer: turns queued commands into header, stuffed data, check and flag bytes.
module bsfe_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bsfe_pkg::bsfe_cmd_t   head,
    input  bsfe_pkg::bsfe_qstat_t q_stat,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output bsfe_pkg::bsfe_out_t   out_data
);

    bsfe_pkg::bsfe_phase_t phase_reg;
    bsfe_pkg::bsfe_phase_t phase_next;
    bsfe_pkg::bsfe_phase_t eff;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    bsfe_pkg::bsfe_out_t   out_data_reg;
    bsfe_pkg::bsfe_out_t   out_data_next;
    bsfe_pkg::bsfe_out_t   emit_data;
    logic                  emit;
    logic                  done;

    // Pick the next byte of the current command and advance the phase.
    always_comb
    begin
        emit = !q_stat.empty && (!out_valid_reg || out_ready);
        if (phase_reg == bsfe_pkg::PH_START)
        begin
            eff = head.hdr ? bsfe_pkg::PH_HDR0 : bsfe_pkg::PH_DATA;
        end
        else
        begin
            eff = phase_reg;
        end
        emit_data.frame_end = 1'b0;
        done                = 1'b0;
        phase_next          = bsfe_pkg::PH_START;
        case (eff)
            bsfe_pkg::PH_HDR0:
            begin
                emit_data.out_byte = bsfe_pkg::FLAG_BYTE;
                phase_next         = bsfe_pkg::PH_HDR1;
            end
            bsfe_pkg::PH_HDR1:
            begin
                emit_data.out_byte = bsfe_pkg::HDR_ADDR;
                phase_next         = bsfe_pkg::PH_HDR2;
            end
            bsfe_pkg::PH_HDR2:
            begin
                emit_data.out_byte = bsfe_pkg::HDR_CTRL;
                phase_next         = bsfe_pkg::PH_HDR3;
            end
            bsfe_pkg::PH_HDR3:
            begin
                emit_data.out_byte = bsfe_pkg::HDR_BCC;
                phase_next         = bsfe_pkg::PH_DATA;
            end
            bsfe_pkg::PH_DATA:
            begin
                if (bsfe_pkg::needs_esc(head.data))
                begin
                    emit_data.out_byte = bsfe_pkg::ESC_BYTE;
                    phase_next         = bsfe_pkg::PH_DATA2;
                end
                else
                begin
                    emit_data.out_byte = head.data;
                    phase_next         = head.last ? bsfe_pkg::PH_CHK : bsfe_pkg::PH_START;
                    done               = !head.last;
                end
            end
            bsfe_pkg::PH_DATA2:
            begin
                emit_data.out_byte = bsfe_pkg::esc_code(head.data);
                phase_next         = head.last ? bsfe_pkg::PH_CHK : bsfe_pkg::PH_START;
                done               = !head.last;
            end
            bsfe_pkg::PH_CHK:
            begin
                if (bsfe_pkg::needs_esc(head.chk))
                begin
                    emit_data.out_byte = bsfe_pkg::ESC_BYTE;
                    phase_next         = bsfe_pkg::PH_CHK2;
                end
                else
                begin
                    emit_data.out_byte = head.chk;
                    phase_next         = bsfe_pkg::PH_FLAG;
                end
            end
            bsfe_pkg::PH_CHK2:
            begin
                emit_data.out_byte = bsfe_pkg::esc_code(head.chk);
                phase_next         = bsfe_pkg::PH_FLAG;
            end
            bsfe_pkg::PH_FLAG:
            begin
                emit_data.out_byte  = bsfe_pkg::FLAG_BYTE;
                emit_data.frame_end = 1'b1;
                done                = 1'b1;
            end
            default:
            begin
                emit_data.out_byte = bsfe_pkg::FLAG_BYTE;
                done               = 1'b1;
            end
        endcase
        emit_data.run_end = done;
        pop               = emit && done;
        if (!emit)
        begin
            phase_next = phase_reg;
        end
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit_data;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        out_valid = out_valid_reg;
        out_data  = out_data_reg;
    end

    // Phase and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= bsfe_pkg::PH_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // A closing flag is always the last byte of its run and carries the flag value.
    a_flag_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.frame_end) |->
            (out_data_reg.run_end && out_data_reg.out_byte == bsfe_pkg::FLAG_BYTE))
        else $error("malformed closing flag");

    // The header starts with the flag and then the address byte.
    a_hdr_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && eff == bsfe_pkg::PH_HDR0) |=> phase_reg == bsfe_pkg::PH_HDR1)
        else $error("header sequence broken");

    // Popping a command returns the serializer to its start phase.
    a_pop_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> phase_reg == bsfe_pkg::PH_START)
        else $error("phase not reset after pop");

endmodule

// ----- hw/rtl/byte_stuffing_frame_encoder_core.sv -----
// An accepted byte is written into the command queue, then the serializer registers it in the output register.
// The serializer sends one output byte per cycle while the output is ready and a command is queued, so an
// input byte gives from one output byte (plain data byte) up to nine (header, escaped data, escaped check, flag).
// A two-entry command queue lets input transfers continue while the serializer is busy.
// Reset (rst_n, asynchronous, active low) closes any open frame, clears the check and
// empties the queue and the output register.
module byte_stuffing_frame_encoder_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bsfe_pkg::bsfe_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bsfe_pkg::bsfe_out_t out_data
);

    bsfe_pkg::bsfe_qstat_t q_stat;
    bsfe_pkg::bsfe_cmd_t   push_cmd;
    bsfe_pkg::bsfe_cmd_t   head;
    logic                  push;
    logic                  pop;

    bsfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    bsfe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    bsfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- tb/byte_stuffing_frame_encoder_core_test.sv -----
// Self-checking testbench for the byte-stuffing frame encoder: framed output bytes vs a predictor.
module byte_stuffing_frame_encoder_core_test;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 20;
    localparam int LONG_HOLD   = 300;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    bsfe_pkg::bsfe_in_t  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    bsfe_pkg::bsfe_out_t out_data;

    // Stimulus waiting to be offered and framed bytes waiting to be seen.
    bsfe_pkg::bsfe_in_t  payload_q[$];
    bsfe_pkg::bsfe_out_t framed_q[$];

    // Predictor state: frame open flag and running XOR of the payload.
    logic       frame_open = 1'b0;
    logic [7:0] bcc_run    = 8'h00;

    // Flow control knobs set by the sequence.
    int   send_idle_pct  = 0;
    int   recv_idle_pct  = 0;
    logic send_pause     = 1'b0;
    int   sink_hold_req  = 0;
    int   sink_hold_left = 0;

    logic in_took        = 1'b0;
    int   stall_cycles   = 0;
    int   mismatch_count = 0;

    byte_stuffing_frame_encoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Append one expected byte; run_end is patched onto the last byte of the burst later.
    task automatic add_byte(input logic [7:0] b, input logic fend);
        bsfe_pkg::bsfe_out_t ob;
        ob.out_byte  = b;
        ob.run_end   = 1'b0;
        ob.frame_end = fend;
        framed_q.push_back(ob);
    endtask

    // Append a byte with flag and escape bytes turned into escape pairs.
    task automatic add_stuffed(input logic [7:0] b);
        if (b == bsfe_pkg::FLAG_BYTE)
        begin
            add_byte(bsfe_pkg::ESC_BYTE, 1'b0);
            add_byte(bsfe_pkg::ESC_FLAG, 1'b0);
        end
        else if (b == bsfe_pkg::ESC_BYTE)
        begin
            add_byte(bsfe_pkg::ESC_BYTE, 1'b0);
            add_byte(bsfe_pkg::ESC_ESC, 1'b0);
        end
        else
        begin
            add_byte(b, 1'b0);
        end
    endtask

    // Work out every output byte that one accepted payload byte causes.
    task automatic predict_framing(input bsfe_pkg::bsfe_in_t item);
        bsfe_pkg::bsfe_out_t tail;
        // Opening a frame sends the header raw.
        if (!frame_open)
        begin
            add_byte(bsfe_pkg::FLAG_BYTE, 1'b0);
            add_byte(bsfe_pkg::HDR_ADDR, 1'b0);
            add_byte(bsfe_pkg::HDR_CTRL, 1'b0);
            add_byte(bsfe_pkg::HDR_BCC, 1'b0);
            frame_open = 1'b1;
            bcc_run    = 8'h00;
        end
        add_stuffed(item.data_byte);
        bcc_run = bcc_run ^ item.data_byte;
        // Closing a frame sends the stuffed check and the closing flag.
        if (item.last_byte)
        begin
            add_stuffed(bcc_run);
            add_byte(bsfe_pkg::FLAG_BYTE, 1'b1);
            frame_open = 1'b0;
            bcc_run    = 8'h00;
        end
        tail = framed_q.pop_back();
        tail.run_end = 1'b1;
        framed_q.push_back(tail);
    endtask

    task automatic push_item(input logic [7:0] b, input logic last);
        bsfe_pkg::bsfe_in_t item;
        item.data_byte = b;
        item.last_byte = last;
        payload_q.push_back(item);
    endtask

    // Queue whole random frames, rich in flag and escape bytes, mostly short.
    task automatic queue_random_frames(input int count);
        int queued;
        int len;
        int r;
        logic [7:0] b;
        queued = 0;
        while (queued < count)
        begin
            r = $urandom_range(99);
            if (r < 8)
                len = 1;
            else if (r < 90)
                len = $urandom_range(8, 2);
            else
                len = $urandom_range(30, 9);
            for (int i = 0; i < len; i++)
            begin
                r = $urandom_range(99);
                if (r < 15)
                    b = bsfe_pkg::FLAG_BYTE;
                else if (r < 30)
                    b = bsfe_pkg::ESC_BYTE;
                else
                    b = 8'($urandom_range(255));
                push_item(b, i == len - 1);
            end
            queued += len;
        end
    endtask

    // Wait until the driver has offered and handed over everything queued.
    task automatic wait_sent();
        while (payload_q.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    // Sender: offers the next item at the falling edge once the previous one is taken.
    always @(negedge clk)
    begin : drive_proc
        logic [31:0] noise;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_took)
        begin
            if (payload_q.size() != 0 && !send_pause
                && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= payload_q.pop_front();
            end
            else
            begin
                noise = $urandom;
                in_valid <= 1'b0;
                in_data  <= noise[8:0];
            end
        end
    end

    // Receiver: random ready, with long hold-offs counted here.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (sink_hold_req != 0)
            begin
                sink_hold_left = sink_hold_req;
                sink_hold_req  = 0;
            end
            if (sink_hold_left != 0)
            begin
                sink_hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Monitor: predict on input transfers, check output transfers, and watch for a hang.
    always @(posedge clk)
    begin
        bsfe_pkg::bsfe_out_t want;
        in_took <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_framing(in_data);
            if (out_valid && out_ready)
            begin
                if (framed_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected byte %02h", out_data.out_byte));
                end
                else
                begin
                    want = framed_q.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  out_data.out_byte, want.out_byte));
                    if (out_data.run_end !== want.run_end)
                        report_mismatch($sformatf("run_end %b, expected %b on byte %02h",
                                                  out_data.run_end, want.run_end,
                                                  want.out_byte));
                    if (out_data.frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end %b, expected %b on byte %02h",
                                                  out_data.frame_end, want.frame_end,
                                                  want.out_byte));
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Phase one: sender idles lightly, receiver idles heavily.
        send_idle_pct = 27;
        recv_idle_pct = 76;

        // Single-byte frames at the extremes and on the special bytes.
        push_item(8'h00, 1'b1);
        push_item(8'hFF, 1'b1);
        push_item(bsfe_pkg::FLAG_BYTE, 1'b1);
        push_item(bsfe_pkg::ESC_BYTE, 1'b1);
        // Every escape value and the header address value as payload.
        push_item(bsfe_pkg::FLAG_BYTE, 1'b0);
        push_item(bsfe_pkg::ESC_BYTE, 1'b0);
        push_item(bsfe_pkg::ESC_FLAG, 1'b0);
        push_item(bsfe_pkg::ESC_ESC, 1'b0);
        push_item(bsfe_pkg::HDR_ADDR, 1'b1);
        // Check that comes out as the flag value, then as the escape value.
        push_item(8'h01, 1'b0);
        push_item(bsfe_pkg::ESC_BYTE, 1'b1);
        push_item(bsfe_pkg::FLAG_BYTE, 1'b0);
        push_item(8'h01, 1'b1);
        // Alternating bit patterns.
        push_item(8'h80, 1'b0);
        push_item(8'h7F, 1'b0);
        push_item(8'hAA, 1'b0);
        push_item(8'h55, 1'b1);
        // Check that cancels to zero.
        push_item(8'h12, 1'b0);
        push_item(8'h12, 1'b1);

        queue_random_frames(80);
        wait_sent();

        // Sender pauses until every framed byte has been seen.
        send_pause = 1'b1;
        while (in_valid || framed_q.size() != 0)
            @(posedge clk);
        send_pause = 1'b0;

        // Phase two: the other way round.
        send_idle_pct = 76;
        recv_idle_pct = 27;
        queue_random_frames(80);
        wait_sent();

        // Phase three: no idling, opened by a long receiver hold-off to back up the input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sink_hold_req = LONG_HOLD;
        queue_random_frames(80);
        wait_sent();

        while (framed_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (framed_q.size() != 0)
            report_mismatch($sformatf("%0d expected bytes never came", framed_q.size()));

        if (mismatch_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/bsfe_pkg.sv
hw/rtl/bsfe_front.sv
hw/rtl/bsfe_queue.sv
hw/rtl/bsfe_back.sv
hw/rtl/byte_stuffing_frame_encoder_core.sv
tb/byte_stuffing_frame_encoder_core_test.sv
